/* design/bearing_range_turn_planner_defines.svh */
// ----------------------------------------------------------------------------
// Bearing range turn planner assertion macros
// Shared property forms for the checker that watches the top level ports.
// ----------------------------------------------------------------------------
`ifndef BEARING_RANGE_TURN_PLANNER_DEFINES_SVH
`define BEARING_RANGE_TURN_PLANNER_DEFINES_SVH

// Same-cycle implication, suspended while reset is held.
`define BRTP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brtp check failed");

// Next-cycle implication, suspended while reset is held.
`define BRTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brtp check failed");

// Next-cycle implication that also holds across reset.
`define BRTP_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("brtp check failed");

`endif

/* design/brtp_pkg.sv */
// ----------------------------------------------------------------------------
// Bearing range turn planner package
// Widths, constants, the arctangent table and the pipeline word type.
// ----------------------------------------------------------------------------
package brtp_pkg;

  localparam int COORD_BITS    = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int FIELD_W  = 16;
  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int FRAC_W   = 16;
  localparam int CW       = DIFF_W + FRAC_W + 2;
  localparam int ACC_W    = 32;
  localparam int ROOT_W   = COORD_BITS + 1;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int S_W      = 2 * SQRT_STEPS;
  localparam int REM_W    = ROOT_W + 3;
  localparam int NSTEP    = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
  localparam int TABLE_LEN = 24;

  localparam int ANGLE_W = 16;
  localparam int DIST_W  = 17;
  localparam int TURN_W  = 11;
  localparam int PHASE_W = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TQ_W       = 10;
  localparam int DQ_W       = 16;

  localparam logic [CFG_IDX_W-1:0] REG_USE_HEADING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_SCALE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SCALE = 2'd2;

  localparam logic [TQ_W-1:0] TURN_SCALE_RST  = 10'd538;
  localparam logic [DQ_W-1:0] DRIVE_SCALE_RST = 16'd128;

  localparam logic [ANGLE_W-1:0] HDG_QUARTER = 16'd9000;
  localparam logic [ANGLE_W-1:0] HDG_WRAP    = 16'd45000;
  localparam logic [ANGLE_W-1:0] FULL_TURN   = 16'd36000;

  localparam logic [ACC_W-1:0] HALF_TURN_ACC = 32'h8000_0000;

  // Reciprocals for exact division of bounded values by 25 and by 5.
  localparam logic [16:0] RECIP25   = 17'd83887;
  localparam int          RECIP25_K = 21;
  localparam logic [25:0] RECIP5A   = 26'd53687092;
  localparam int          RECIP5A_K = 28;
  localparam logic [26:0] RECIP5B   = 27'd107374183;
  localparam int          RECIP5B_K = 29;

  typedef struct packed {
    logic                    vld;
    logic                    zero;
    logic [ANGLE_W-1:0]      math;
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic [ACC_W-1:0]        acc;
    logic [S_W-1:0]          s;
    logic [REM_W-1:0]        rem;
    logic [ROOT_W-1:0]       root;
  } brtp_word_t;

  // atan(2^-i) in units where a full turn is 2^32.
  function automatic logic [ACC_W-1:0] atan_turn(input logic [4:0] idx);
    logic [ACC_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* design/brtp_front.sv */
// ----------------------------------------------------------------------------
// Bearing range turn planner front end
// Differences, heading conversion, squares and CORDIC pre-rotation.
// ----------------------------------------------------------------------------
module brtp_front
  import brtp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [FIELD_W-1:0] cur_x,
  input  logic [FIELD_W-1:0] cur_y,
  input  logic [FIELD_W-1:0] hdg,
  input  logic [FIELD_W-1:0] tgt_x,
  input  logic [FIELD_W-1:0] tgt_y,
  output brtp_word_t         word_out
);

  logic                     v1_r, v2_r, v3_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic [ANGLE_W-1:0]       m1_r, m2_r, m1_nxt;
  logic [COORD_BITS-1:0]    adx, ady;
  logic signed [DIFF_W-1:0] ndx, ndy;
  logic [2*COORD_BITS-1:0]  sqx_r, sqy_r;
  logic signed [CW-1:0]     x2_r, y2_r;
  logic [ACC_W-1:0]         acc2_r;
  logic                     zero2_r;
  brtp_word_t               w3_r, w3_nxt;

  // Stage one: coordinate differences and the math angle of the heading.
  always_comb begin
    dx_nxt = $signed({tgt_x[COORD_BITS-1], tgt_x[COORD_BITS-1:0]})
           - $signed({cur_x[COORD_BITS-1], cur_x[COORD_BITS-1:0]});
    dy_nxt = $signed({tgt_y[COORD_BITS-1], tgt_y[COORD_BITS-1:0]})
           - $signed({cur_y[COORD_BITS-1], cur_y[COORD_BITS-1:0]});
    if (hdg <= HDG_QUARTER) begin
      m1_nxt = HDG_QUARTER - hdg;
    end else if (hdg > HDG_WRAP) begin
      m1_nxt = hdg - HDG_WRAP;
    end else begin
      m1_nxt = HDG_WRAP - hdg;
    end
  end

  // Stage two: magnitudes squared and the vector folded into the right half plane.
  always_comb begin
    ndx = dx_r[DIFF_W-1] ? -dx_r : dx_r;
    ndy = dx_r[DIFF_W-1] ? -dy_r : dy_r;
    adx = ndx[COORD_BITS-1:0];
    ady = dy_r[DIFF_W-1] ? COORD_BITS'(-dy_r) : dy_r[COORD_BITS-1:0];
  end

  // Stage three: sum of squares feeds the square root.
  always_comb begin
    w3_nxt      = '0;
    w3_nxt.vld  = v2_r;
    w3_nxt.zero = zero2_r;
    w3_nxt.math = m2_r;
    w3_nxt.x    = x2_r;
    w3_nxt.y    = y2_r;
    w3_nxt.acc  = acc2_r;
    w3_nxt.s    = S_W'(sqx_r) + S_W'(sqy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      m1_r    <= m1_nxt;
      m2_r    <= m1_r;
      sqx_r   <= adx * adx;
      sqy_r   <= ady * ady;
      x2_r    <= $signed({{(CW-DIFF_W-FRAC_W){ndx[DIFF_W-1]}}, ndx, {FRAC_W{1'b0}}});
      y2_r    <= $signed({{(CW-DIFF_W-FRAC_W){ndy[DIFF_W-1]}}, ndy, {FRAC_W{1'b0}}});
      acc2_r  <= dx_r[DIFF_W-1] ? HALF_TURN_ACC : '0;
      zero2_r <= (dx_r == '0) && (dy_r == '0);
      w3_r    <= w3_nxt;
    end
  end

  always_comb begin
    word_out     = w3_r;
    word_out.vld = v3_r;
  end

endmodule

/* design/brtp_core.sv */
// ----------------------------------------------------------------------------
// Bearing range turn planner core
// One register stage per CORDIC rotation and per square root digit.
// ----------------------------------------------------------------------------
module brtp_core
  import brtp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  brtp_word_t word_in,
  output brtp_word_t word_out
);

  brtp_word_t stage_r [NSTEP];

  for (genvar i = 0; i < NSTEP; i++) begin : g_stage
    brtp_word_t prv, stage_nxt;
    logic [REM_W-1:0] remsh, trial;

    if (i == 0) begin : g_first
      assign prv = word_in;
    end else begin : g_rest
      assign prv = stage_r[i-1];
    end

    always_comb begin
      stage_nxt = prv;
      remsh     = '0;
      trial     = '0;
      if (i < CORDIC_STAGES && i < TABLE_LEN) begin
        if (!prv.y[CW-1]) begin
          stage_nxt.x   = prv.x + ($signed(prv.y) >>> i);
          stage_nxt.y   = prv.y - ($signed(prv.x) >>> i);
          stage_nxt.acc = prv.acc + atan_turn(5'(i));
        end else begin
          stage_nxt.x   = prv.x - ($signed(prv.y) >>> i);
          stage_nxt.y   = prv.y + ($signed(prv.x) >>> i);
          stage_nxt.acc = prv.acc - atan_turn(5'(i));
        end
      end
      if (i < SQRT_STEPS) begin
        remsh = {prv.rem[REM_W-3:0], prv.s[S_W-1-2*i -: 2]};
        trial = {1'b0, prv.root, 2'b01};
        if (remsh >= trial) begin
          stage_nxt.rem  = remsh - trial;
          stage_nxt.root = {prv.root[ROOT_W-2:0], 1'b1};
        end else begin
          stage_nxt.rem  = remsh;
          stage_nxt.root = {prv.root[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r[i].vld <= 1'b0;
      end else if (en) begin
        stage_r[i] <= stage_nxt;
      end
    end
  end

  assign word_out = stage_r[NSTEP-1];

endmodule

/* design/brtp_back.sv */
// ----------------------------------------------------------------------------
// Bearing range turn planner back end
// Angle scaling, heading subtraction, timing products and the output register.
// ----------------------------------------------------------------------------
module brtp_back
  import brtp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  brtp_word_t         word_in,
  input  logic               use_heading,
  input  logic [TQ_W-1:0]    turn_scale,
  input  logic [DQ_W-1:0]    drive_scale,
  output logic               out_vld,
  output logic [ANGLE_W-1:0] angle,
  output logic [DIST_W-1:0]  distance,
  output logic [TURN_W-1:0]  turn_ms,
  output logic [PHASE_W-1:0] cruise_ms,
  output logic [PHASE_W-1:0] slow_ms,
  output logic [PHASE_W-1:0] creep_ms
);

  localparam int HP_W  = ACC_W + ANGLE_W;
  localparam int TP_W  = ANGLE_W + TQ_W;
  localparam int DP_W  = DIST_W + DQ_W;
  localparam int TQ10_W = TP_W - 10;
  localparam int SQ_W  = DP_W - 8;
  localparam int CQ_W  = DP_W + 2 - 9;

  logic                v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [ANGLE_W-1:0]  h1_r, m1_r, a2_r, a3_r;
  logic                z1_r;
  logic [DIST_W-1:0]   d1_r, d2_r, d3_r;
  logic [HP_W-1:0]     hprod;
  logic [ROOT_W:0]     rnd;
  logic [DIST_W-1:0]   d1_nxt;
  logic [ANGLE_W-1:0]  bear, a2_nxt;
  logic signed [ANGLE_W+1:0] diff;
  logic [TP_W-1:0]     tp_r;
  logic [DP_W-1:0]     dp_r, dp4_r;
  logic [DP_W+1:0]     dp3;
  logic [TQ10_W+17-1:0] tq_r;
  logic [SQ_W+26-1:0]  sq_r;
  logic [CQ_W+27-1:0]  cq_r;
  logic [TQ10_W+17-1:0] tq_nxt;
  logic [SQ_W+26-1:0]  sq_nxt;
  logic [CQ_W+27-1:0]  cq_nxt;
  logic [DP_W-1:0]     cruise_full;
  logic [CQ_W+27-1:0]  slow_full, creep_full;
  logic [ANGLE_W-1:0]  a4_r;
  logic [DIST_W-1:0]   d4_r;
  logic [ANGLE_W-1:0]  angle_r;
  logic [DIST_W-1:0]   dist_r;
  logic [TURN_W-1:0]   turn_r;
  logic [PHASE_W-1:0]  cruise_r, slow_r, creep_r;

  // Stage one: accumulator to hundredths of a degree and rounded distance.
  always_comb begin
    hprod = HP_W'(word_in.acc) * HP_W'(FULL_TURN) + HP_W'(HALF_TURN_ACC);
    rnd   = {1'b0, word_in.root} + (ROOT_W+1)'(word_in.rem > REM_W'(word_in.root));
    if (rnd > (ROOT_W+1)'({DIST_W{1'b1}})) begin
      d1_nxt = '1;
    end else begin
      d1_nxt = DIST_W'(rnd);
    end
  end

  // Stage two: zero vector and full-turn fold, then the optional heading offset.
  always_comb begin
    bear = (z1_r || (h1_r >= FULL_TURN)) ? '0 : h1_r;
    diff = $signed({2'b00, bear}) - $signed({2'b00, m1_r});
    if (!use_heading) begin
      a2_nxt = bear;
    end else if (diff[ANGLE_W+1]) begin
      a2_nxt = ANGLE_W'(diff + $signed({2'b00, FULL_TURN}));
    end else begin
      a2_nxt = ANGLE_W'(diff);
    end
  end

  // Stage four: divisions by 25 and by 5 as reciprocal products.
  always_comb begin
    dp3    = {dp_r, 1'b0} + (DP_W+2)'(dp_r);
    tq_nxt = (TQ10_W+17)'(tp_r[TP_W-1:10]) * (TQ10_W+17)'(RECIP25);
    sq_nxt = (SQ_W+26)'(dp_r[DP_W-1:8]) * (SQ_W+26)'(RECIP5A);
    cq_nxt = (CQ_W+27)'(dp3[DP_W+1:9]) * (CQ_W+27)'(RECIP5B);
  end

  // Output stage: final shifts and saturation.
  always_comb begin
    cruise_full = dp4_r >> 9;
    slow_full   = (CQ_W+27)'(sq_r >> RECIP5A_K);
    creep_full  = cq_r >> RECIP5B_K;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= word_in.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1_r  <= hprod[HP_W-1:ACC_W];
      m1_r  <= word_in.math;
      z1_r  <= word_in.zero;
      d1_r  <= d1_nxt;
      a2_r  <= a2_nxt;
      d2_r  <= d1_r;
      tp_r  <= TP_W'(a2_r) * TP_W'(turn_scale);
      dp_r  <= DP_W'(d2_r) * DP_W'(drive_scale);
      a3_r  <= a2_r;
      d3_r  <= d2_r;
      tq_r  <= tq_nxt;
      sq_r  <= sq_nxt;
      cq_r  <= cq_nxt;
      dp4_r <= dp_r;
      a4_r  <= a3_r;
      d4_r  <= d3_r;
      angle_r  <= a4_r;
      dist_r   <= d4_r;
      turn_r   <= TURN_W'(tq_r >> RECIP25_K);
      cruise_r <= (cruise_full > DP_W'({PHASE_W{1'b1}})) ? '1 : PHASE_W'(cruise_full);
      slow_r   <= (slow_full > (CQ_W+27)'({PHASE_W{1'b1}})) ? '1 : PHASE_W'(slow_full);
      creep_r  <= (creep_full > (CQ_W+27)'({PHASE_W{1'b1}})) ? '1 : PHASE_W'(creep_full);
    end
  end

  assign out_vld   = v5_r;
  assign angle     = angle_r;
  assign distance  = dist_r;
  assign turn_ms   = turn_r;
  assign cruise_ms = cruise_r;
  assign slow_ms   = slow_r;
  assign creep_ms  = creep_r;

endmodule

/* design/bearing_range_turn_planner.sv */
// ----------------------------------------------------------------------------
// Bearing range turn planner
// Bearing, distance, spin time and drive phase times for one position word.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one word per cycle holding the present
// position, the compass heading and the goal position. The result channel
// returns one word per input word, in order: the turn angle in hundredths of
// a degree, the rounded distance, the spin time and the cruise, slow and
// creep drive times in milliseconds.
// From the accepting edge to out_valid, the word passes twenty-five registers,
// the first of which loads at the accepting edge:
// three front stages, seventeen CORDIC and square root stages (one root digit
// per stage, plus one rotation in each of the first sixteen) and five back
// stages ending in the output register.
// Throughput is one word per cycle, set by the fully pipelined datapath.
// When the receiver stalls, the whole pipeline holds and in_ready drops, so
// no word is lost or repeated; a word enters as soon as the output register
// is empty or being drained.
// Reset clears all valid bits and loads the registers with their defaults:
// heading compensation on, turn scale 538 and drive scale 128 (Q8).
// The configuration port writes one register per enabled cycle; idle use is the user's duty, not enforced.
// ----------------------------------------------------------------------------
module bearing_range_turn_planner
  import brtp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FIELD_W-1:0]    in_current_x,
  input  logic [FIELD_W-1:0]    in_current_y,
  input  logic [FIELD_W-1:0]    in_heading,
  input  logic [FIELD_W-1:0]    in_target_x,
  input  logic [FIELD_W-1:0]    in_target_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ANGLE_W-1:0]    out_turn_angle,
  output logic [DIST_W-1:0]     out_distance,
  output logic [TURN_W-1:0]     out_turn_time_ms,
  output logic [PHASE_W-1:0]    out_cruise_time_ms,
  output logic [PHASE_W-1:0]    out_slow_time_ms,
  output logic [PHASE_W-1:0]    out_creep_time_ms,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic            use_heading_r;
  logic [TQ_W-1:0] turn_scale_r;
  logic [DQ_W-1:0] drive_scale_r;
  logic            adv;
  brtp_word_t      front_word, core_word;

  // The pipeline moves as one whenever the output register can take a word.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_heading_r <= 1'b1;
      turn_scale_r  <= TURN_SCALE_RST;
      drive_scale_r <= DRIVE_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_USE_HEADING: use_heading_r <= cfg_wdata[0];
        REG_TURN_SCALE:  turn_scale_r  <= cfg_wdata[TQ_W-1:0];
        REG_DRIVE_SCALE: drive_scale_r <= cfg_wdata[DQ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  brtp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (in_valid),
    .cur_x    (in_current_x),
    .cur_y    (in_current_y),
    .hdg      (in_heading),
    .tgt_x    (in_target_x),
    .tgt_y    (in_target_y),
    .word_out (front_word)
  );

  brtp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .word_in  (front_word),
    .word_out (core_word)
  );

  brtp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .word_in     (core_word),
    .use_heading (use_heading_r),
    .turn_scale  (turn_scale_r),
    .drive_scale (drive_scale_r),
    .out_vld     (out_valid),
    .angle       (out_turn_angle),
    .distance    (out_distance),
    .turn_ms     (out_turn_time_ms),
    .cruise_ms   (out_cruise_time_ms),
    .slow_ms     (out_slow_time_ms),
    .creep_ms    (out_creep_time_ms)
  );

endmodule

/* design/brtp_checker.sv */
// ----------------------------------------------------------------------------
// Bearing range turn planner checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "bearing_range_turn_planner_defines.svh"

module brtp_checker
  import brtp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [FIELD_W-1:0]    in_current_x,
  input logic [FIELD_W-1:0]    in_current_y,
  input logic [FIELD_W-1:0]    in_heading,
  input logic [FIELD_W-1:0]    in_target_x,
  input logic [FIELD_W-1:0]    in_target_y,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [ANGLE_W-1:0]    out_turn_angle,
  input logic [DIST_W-1:0]     out_distance,
  input logic [TURN_W-1:0]     out_turn_time_ms,
  input logic [PHASE_W-1:0]    out_cruise_time_ms,
  input logic [PHASE_W-1:0]    out_slow_time_ms,
  input logic [PHASE_W-1:0]    out_creep_time_ms,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  // A stalled result word keeps its valid and its angle.
  `BRTP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_turn_angle))

  // The input side stalls exactly when a result word is held back.
  `BRTP_ASSERT_NOW(a_ready_rule, 1'b1, in_ready == (!out_valid || out_ready))

  // Angles always lie within one turn.
  `BRTP_ASSERT_NOW(a_angle_range, out_valid, out_turn_angle < FULL_TURN)

  // No result word right after reset.
  `BRTP_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid)

endmodule

bind bearing_range_turn_planner brtp_checker u_brtp_checker (.*);
